/* rtl/klst_pkg.sv */
// shared types and constants for the keyed latency statistics table
// no dependencies; imported by every module of the block
`default_nettype none

package klst_pkg;

  localparam int TABLE_DEPTH = 512;
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam int PID_W  = 32;
  localparam int CID_W  = 10;
  localparam int KEY_W  = PID_W + CID_W;
  localparam int DUR_W  = 48;
  localparam int SUM_W  = 64;
  localparam int CALL_W = 32;
  localparam int ERR_W  = 32;
  localparam int TOT_W  = 32;
  localparam int SLOT_W = 9;

  typedef enum logic [1:0] {
    ST_HIT  = 2'd0,
    ST_NEW  = 2'd1,
    ST_FULL = 2'd2,
    ST_IGN  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIN
  } state_t;

  typedef struct packed {
    logic [CALL_W-1:0] count;
    logic [SUM_W-1:0]  sum;
    logic [DUR_W-1:0]  peak;
    logic [ERR_W-1:0]  errors;
  } stats_t;

  // controller to datapath
  typedef struct packed {
    logic load_item;
    logic scan;
    logic take_hit;
    logic take_new;
    logic take_full;
    logic take_ignore;
    logic finish;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic item_ok;
    logic hit;
    logic scan_end;
    logic room;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

/* rtl/klst_ctrl.sv */
// controller state machine: accept, key scan, result hand-off
// depends on klst_pkg
`default_nettype none

module klst_ctrl
  import klst_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire dp_stat_t st,
  output dp_cmd_t       cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (!st.item_ok) begin
          cmd.take_ignore = 1'b1;
          state_next      = S_FIN;
        end else if (st.hit) begin
          cmd.take_hit = 1'b1;
          state_next   = S_FIN;
        end else if (st.scan_end) begin
          if (st.room) begin
            cmd.take_new = 1'b1;
          end else begin
            cmd.take_full = 1'b1;
          end
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (st.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_one_outcome: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.take_hit, cmd.take_new, cmd.take_full, cmd.take_ignore}))
    else $error("more than one outcome chosen for one item");

  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall)
    else $error("input open while an item is in work");

  a_finish_state: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (state == S_FIN))
    else $error("result loaded outside the hand-off state");

endmodule

`default_nettype wire

/* rtl/klst_dp.sv */
// datapath: key and statistics memories, scan pipeline, counters, result register
// depends on klst_pkg
`default_nettype none

module klst_dp
  import klst_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire dp_cmd_t           cmd,
  output dp_stat_t               st,
  input  wire logic [PID_W-1:0]  process_id,
  input  wire logic [CID_W-1:0]  call_id,
  input  wire logic [DUR_W-1:0]  duration,
  input  wire logic              failed,
  input  wire logic              record_ok,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [1:0]             status,
  output logic [SLOT_W-1:0]      slot,
  output logic [CALL_W-1:0]      call_count,
  output logic [SUM_W-1:0]       latency_sum,
  output logic [DUR_W-1:0]       latency_peak,
  output logic [ERR_W-1:0]       error_count,
  output logic [TOT_W-1:0]       received_total,
  output logic [TOT_W-1:0]       dropped_total
);

  logic [KEY_W-1:0] key_mem [TABLE_DEPTH];
  stats_t           stats_mem [TABLE_DEPTH];

  // latched item
  logic [KEY_W-1:0] item_key;
  logic [DUR_W-1:0] item_dur;
  logic             item_failed;
  logic             item_ok;

  // scan pipeline
  logic [CNT_W-1:0] rd_idx;
  logic             pend;
  logic [IDX_W-1:0] pend_idx;
  logic [KEY_W-1:0] key_q;
  stats_t           stats_q;
  logic             rd_more;

  // outcome of the scan
  status_t          res_status;
  logic [IDX_W-1:0] sel_idx;
  logic             new_base;

  logic [CNT_W-1:0] used;
  logic [TOT_W-1:0] received;
  logic [TOT_W-1:0] dropped;

  stats_t           base;
  stats_t           upd;
  logic [SUM_W:0]   sum_wide;
  logic             counted;
  logic             is_drop;
  logic             is_entry;
  logic [TOT_W-1:0] received_next;
  logic [TOT_W-1:0] dropped_next;

  assign rd_more = (rd_idx < used);

  assign st.item_ok  = item_ok;
  assign st.hit      = pend && (key_q == item_key);
  assign st.scan_end = !pend && !rd_more;
  assign st.room     = (used != CNT_W'(TABLE_DEPTH));
  assign st.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_key    <= {call_id, process_id};
      item_dur    <= duration;
      item_failed <= failed;
      item_ok     <= record_ok;
    end
  end

  // scan issues one key read per cycle; the key is compared in the cycle after its read
  always_ff @(posedge clk) begin
    if (rst) begin
      pend   <= 1'b0;
      rd_idx <= '0;
    end else if (cmd.load_item) begin
      pend   <= 1'b0;
      rd_idx <= '0;
    end else if (cmd.scan) begin
      pend <= rd_more;
      if (rd_more) begin
        rd_idx <= rd_idx + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan && rd_more) begin
      pend_idx <= rd_idx[IDX_W-1:0];
    end
  end

  // key memory: one write, one read
  always_ff @(posedge clk) begin
    if (cmd.take_new) begin
      key_mem[used[IDX_W-1:0]] <= item_key;
    end
    if (cmd.scan && rd_more) begin
      key_q <= key_mem[rd_idx[IDX_W-1:0]];
    end
  end

  // stats memory read follows the compared entry, so a hit has its stats next cycle
  always_ff @(posedge clk) begin
    if (cmd.finish && is_entry) begin
      stats_mem[sel_idx] <= upd;
    end
    if (cmd.scan) begin
      stats_q <= stats_mem[pend_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_hit) begin
      res_status <= ST_HIT;
      sel_idx    <= pend_idx;
      new_base   <= 1'b0;
    end else if (cmd.take_new) begin
      res_status <= ST_NEW;
      sel_idx    <= used[IDX_W-1:0];
      new_base   <= 1'b1;
    end else if (cmd.take_full) begin
      res_status <= ST_FULL;
    end else if (cmd.take_ignore) begin
      res_status <= ST_IGN;
    end
  end

  // saturating update
  always_comb begin
    base = new_base ? '0 : stats_q;
    sum_wide = {1'b0, base.sum} + {{(SUM_W + 1 - DUR_W){1'b0}}, item_dur};
    upd.count  = (base.count == '1) ? base.count : base.count + CALL_W'(1);
    upd.sum    = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
    upd.peak   = (item_dur > base.peak) ? item_dur : base.peak;
    upd.errors = (item_failed && (base.errors != '1)) ? base.errors + ERR_W'(1)
                                                        : base.errors;
  end

  assign is_entry      = (res_status == ST_HIT) || (res_status == ST_NEW);
  assign is_drop       = (res_status == ST_FULL);
  assign counted       = (res_status != ST_IGN);
  assign received_next = received + TOT_W'(counted);
  assign dropped_next  = dropped + TOT_W'(is_drop);

  always_ff @(posedge clk) begin
    if (rst) begin
      used     <= '0;
      received <= '0;
      dropped  <= '0;
    end else begin
      if (cmd.take_new) begin
        used <= used + CNT_W'(1);
      end
      if (cmd.finish) begin
        received <= received_next;
        dropped  <= dropped_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status         <= res_status;
      slot           <= is_entry ? SLOT_W'(sel_idx) : '0;
      call_count     <= is_entry ? upd.count : '0;
      latency_sum    <= is_entry ? upd.sum : '0;
      latency_peak   <= is_entry ? upd.peak : '0;
      error_count    <= is_entry ? upd.errors : '0;
      received_total <= received_next;
      dropped_total  <= dropped_next;
    end
  end

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= CNT_W'(TABLE_DEPTH))
    else $error("entry fill count beyond table depth");

  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> st.out_free)
    else $error("result loaded over an untaken result");

  a_drop_count: assert property (@(posedge clk) disable iff (rst)
    (cmd.finish && is_drop) |=> dropped == $past(dropped) + TOT_W'(1))
    else $error("dropped total not bumped on a full-table event");

endmodule

`default_nettype wire

/* rtl/keyed_latency_stats_table_core.sv */
// top level of the keyed latency statistics table
// depends on klst_pkg, klst_ctrl and klst_dp
`default_nettype none

//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------------
//  in      | in_valid / in_stall  | process_id call_id duration failed record_ok
//  out     | out_valid / out_stall| status slot call_count latency_sum
//          |                      | latency_peak error_count received_total
//          |                      | dropped_total
//
//  ignored record: decided at once in S_SCAN; hit on entry i: scan stops when entry i matches
//  miss: every used entry is compared (none on an empty table), at most TABLE_DEPTH (512),
//  through the single read port of the key memory, walked one entry per cycle
//  one item at a time; in_stall is low only while no item is in work
//  a finished result waits in the output register; the next item is taken meanwhile
//  reset clears the fill count and totals; table entries are written before read

module keyed_latency_stats_table_core
  import klst_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [PID_W-1:0]  process_id,
  input  wire logic [CID_W-1:0]  call_id,
  input  wire logic [DUR_W-1:0]  duration,
  input  wire logic              failed,
  input  wire logic              record_ok,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [1:0]             status,
  output logic [SLOT_W-1:0]      slot,
  output logic [CALL_W-1:0]      call_count,
  output logic [SUM_W-1:0]       latency_sum,
  output logic [DUR_W-1:0]       latency_peak,
  output logic [ERR_W-1:0]       error_count,
  output logic [TOT_W-1:0]       received_total,
  output logic [TOT_W-1:0]       dropped_total
);

  // command and status between controller and datapath
  dp_cmd_t  cmd;
  dp_stat_t st;

  // controller: idle, scan the used entries, then hand the result off
  klst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // datapath: memories, scan compare, saturating update, totals, result register
  klst_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .st             (st),
    .process_id     (process_id),
    .call_id        (call_id),
    .duration       (duration),
    .failed         (failed),
    .record_ok      (record_ok),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .slot           (slot),
    .call_count     (call_count),
    .latency_sum    (latency_sum),
    .latency_peak   (latency_peak),
    .error_count    (error_count),
    .received_total (received_total),
    .dropped_total  (dropped_total)
  );

endmodule

`default_nettype wire
